### hdl/assert_macros.svh
// Assertion helpers for the RTL; included by sorted_name_table_insert.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every rising clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/snt_pkg.sv
package snt_pkg;

    // Table geometry
    localparam int LIST_MAX = 8;
    localparam int NAME_LEN = 80;
    localparam int ROWS     = LIST_MAX + 1;           // one spare row collects the pending name
    localparam int SLOT_W   = $clog2(LIST_MAX);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int CNT_W    = $clog2(LIST_MAX + 1);
    localparam int POS_W    = $clog2(NAME_LEN);

    // Result status codes
    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_DATA     = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    // Operation codes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic [ROW_W-1:0] t_row;

    // Insert command to the slot map
    typedef struct packed {
        logic              ins;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  len;
    } t_map_ctl;

endpackage

### hdl/snt_slot_map.sv
// Slot-to-row map and per-slot name lengths.
// Position LIST_MAX of the map always holds the row collecting the pending name.
// Insert at slot k rotates positions k..LIST_MAX right by one, so the pending
// row lands at k and an unused row becomes the next pending row.
module snt_slot_map import snt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_map_ctl          i_ctl,
    input  logic [SLOT_W-1:0] i_sel,
    output t_row              o_sel_row,
    output logic [POS_W-1:0]  o_sel_len,
    output t_row              o_pend_row
);

    t_row             r_map [0:LIST_MAX];
    t_row             n_map [0:LIST_MAX];
    logic [POS_W-1:0] r_len [0:LIST_MAX-1];
    logic [POS_W-1:0] n_len [0:LIST_MAX-1];

    // Rotation on insert, each position looks at itself, its lower neighbor and the pending position only
    always_comb begin
        n_map[0] = (i_ctl.ins && i_ctl.slot == '0) ? r_map[LIST_MAX] : r_map[0];
        for (int j = 1; j <= LIST_MAX; j++) begin
            if (i_ctl.ins && ROW_W'(j) == ROW_W'(i_ctl.slot)) begin
                n_map[j] = r_map[LIST_MAX];
            end else if (i_ctl.ins && ROW_W'(j) > ROW_W'(i_ctl.slot)) begin
                n_map[j] = r_map[j-1];
            end else begin
                n_map[j] = r_map[j];
            end
        end
        n_len[0] = (i_ctl.ins && i_ctl.slot == '0) ? i_ctl.len : r_len[0];
        for (int j = 1; j < LIST_MAX; j++) begin
            if (i_ctl.ins && SLOT_W'(j) == i_ctl.slot) begin
                n_len[j] = i_ctl.len;
            end else if (i_ctl.ins && SLOT_W'(j) > i_ctl.slot) begin
                n_len[j] = r_len[j-1];
            end else begin
                n_len[j] = r_len[j];
            end
        end
    end

    // Map must stay a permutation, so it resets to identity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= LIST_MAX; j++) begin
                r_map[j] <= ROW_W'(j);
            end
        end else begin
            for (int j = 0; j <= LIST_MAX; j++) begin
                r_map[j] <= n_map[j];
            end
        end
    end

    // Lengths are only read for live slots
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < LIST_MAX; j++) begin
            r_len[j] <= n_len[j];
        end
    end

    assign o_sel_row  = r_map[ROW_W'(i_sel)];
    assign o_sel_len  = r_len[i_sel];
    assign o_pend_row = r_map[LIST_MAX];

endmodule

### hdl/sorted_name_table_insert.sv
// Sorted name table. Names arrive one character per input beat (op 0, last
// closes the name) and are kept in ascending unsigned byte order, up to eight
// names of 79 characters each; extra characters are dropped and reported as
// truncated when the name closes. A character beat gives no result. On close
// the block first checks for room, then walks the stored names in slot order
// with one byte comparator: each byte compared passes through a scan and an
// evaluate state, and a slot where the shorter name runs out, or the end of the
// table, is settled in the scan state. The name is then placed and the result
// posted; a full table is answered with no walk. Placing a name never copies
// text: a slot-to-row map rotates, and the name memory (one write port, two
// registered read ports) keeps the bytes where they were collected. A read
// beat (op 1) returns one stored byte. Posting waits while the previous result
// still sits unaccepted in the output register, and the input is not ready
// again until the result is posted.
`include "assert_macros.svh"

module sorted_name_table_insert import snt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_op,
    input  logic [7:0] i_char_in,
    input  logic       i_last,
    input  logic [2:0] i_read_slot,
    input  logic [6:0] i_read_pos,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_status,
    output logic [2:0] o_insert_slot,
    output logic [3:0] o_count,
    output logic       o_truncated,
    output logic [7:0] o_char_out
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLOSE  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_INSERT = 3'd4;
    localparam logic [2:0] S_RDCHK  = 3'd5;
    localparam logic [2:0] S_RDDAT  = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [POS_W-1:0]  r_plen, n_plen;
    logic              r_povf, n_povf;
    logic [SLOT_W-1:0] r_k, n_k;
    logic [POS_W-1:0]  r_i, n_i;
    logic [2:0]        r_rslot, n_rslot;
    logic [6:0]        r_rpos, n_rpos;

    logic [1:0]        r_res_status, n_res_status;
    logic [2:0]        r_res_slot, n_res_slot;
    logic              r_res_trunc, n_res_trunc;
    logic [7:0]        r_res_char, n_res_char;

    logic              r_o_valid, n_o_valid;
    logic [1:0]        r_o_status, n_o_status;
    logic [2:0]        r_o_slot, n_o_slot;
    logic [3:0]        r_o_count, n_o_count;
    logic              r_o_trunc, n_o_trunc;
    logic [7:0]        r_o_char, n_o_char;

    logic [7:0]        r_mem [0:ROWS-1][0:NAME_LEN-1];
    logic [7:0]        r_rd_a, r_rd_b;

    t_map_ctl          w_ctl;
    logic [SLOT_W-1:0] w_sel;
    t_row              w_sel_row, w_pend_row;
    logic [POS_W-1:0]  w_sel_len, w_n;
    logic [POS_W-1:0]  w_b_pos;
    logic              w_accept, w_we;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_we     = w_accept && (i_op == OP_CHAR) && (r_plen < POS_W'(NAME_LEN - 1));

    // Slot lookup: read beats address by slot, the walk by the scan index
    assign w_sel   = (r_state == S_RDCHK) ? SLOT_W'(r_rslot) : r_k;
    assign w_b_pos = (r_state == S_RDCHK) ? POS_W'(r_rpos) : r_i;
    assign w_n     = (r_plen < w_sel_len) ? r_plen : w_sel_len;

    snt_slot_map u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_sel      (w_sel),
        .o_sel_row  (w_sel_row),
        .o_sel_len  (w_sel_len),
        .o_pend_row (w_pend_row)
    );

    // Name memory: pending characters written, two registered reads
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_pend_row][r_plen] <= i_char_in;
        end
        r_rd_a <= r_mem[w_pend_row][r_i];
        r_rd_b <= r_mem[w_sel_row][w_b_pos];
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_plen       = r_plen;
        n_povf       = r_povf;
        n_k          = r_k;
        n_i          = r_i;
        n_rslot      = r_rslot;
        n_rpos       = r_rpos;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_trunc  = r_res_trunc;
        n_res_char   = r_res_char;
        n_o_valid    = r_o_valid && !i_ready;
        n_o_status   = r_o_status;
        n_o_slot     = r_o_slot;
        n_o_count    = r_o_count;
        n_o_trunc    = r_o_trunc;
        n_o_char     = r_o_char;
        w_ctl        = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_READ) begin
                        n_rslot = i_read_slot;
                        n_rpos  = i_read_pos;
                        n_state = S_RDCHK;
                    end else begin
                        if (w_we) begin
                            n_plen = r_plen + 1'b1;
                        end else begin
                            n_povf = 1'b1;
                        end
                        if (i_last) begin
                            n_state = S_CLOSE;
                        end
                    end
                end
            end
            S_CLOSE: begin
                if (r_count == CNT_W'(LIST_MAX)) begin
                    n_res_status = STAT_FULL;
                    n_res_slot   = '0;
                    n_res_trunc  = r_povf;
                    n_res_char   = '0;
                    n_plen       = '0;
                    n_povf       = 1'b0;
                    n_state      = S_EMIT;
                end else begin
                    n_k     = '0;
                    n_i     = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (CNT_W'(r_k) == r_count) begin
                    n_state = S_INSERT;
                end else if (r_i == w_n) begin
                    // common prefix exhausted: shorter name sorts first
                    if (r_plen < w_sel_len) begin
                        n_state = S_INSERT;
                    end else begin
                        n_k = r_k + 1'b1;
                        n_i = '0;
                    end
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_rd_a != r_rd_b) begin
                    if (r_rd_a < r_rd_b) begin
                        n_state = S_INSERT;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_i     = '0;
                        n_state = S_SCAN;
                    end
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_INSERT: begin
                w_ctl.ins    = 1'b1;
                w_ctl.slot   = r_k;
                w_ctl.len    = r_plen;
                n_count      = r_count + 1'b1;
                n_res_status = STAT_INSERTED;
                n_res_slot   = 3'(r_k);
                n_res_trunc  = r_povf;
                n_res_char   = '0;
                n_plen       = '0;
                n_povf       = 1'b0;
                n_state      = S_EMIT;
            end
            S_RDCHK: begin
                n_res_slot  = '0;
                n_res_trunc = 1'b0;
                n_res_char  = '0;
                if (CNT_W'(r_rslot) >= r_count) begin
                    n_res_status = STAT_EMPTY;
                    n_state      = S_EMIT;
                end else if (POS_W'(r_rpos) >= w_sel_len || r_rpos >= 7'(NAME_LEN)) begin
                    n_res_status = STAT_DATA;
                    n_state      = S_EMIT;
                end else begin
                    n_res_status = STAT_DATA;
                    n_state      = S_RDDAT;
                end
            end
            S_RDDAT: begin
                n_res_char = r_rd_b;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_slot   = r_res_slot;
                    n_o_count  = 4'(r_count);
                    n_o_trunc  = r_res_trunc;
                    n_o_char   = r_res_char;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_plen    <= '0;
            r_povf    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_plen    <= n_plen;
            r_povf    <= n_povf;
            r_o_valid <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_k          <= n_k;
        r_i          <= n_i;
        r_rslot      <= n_rslot;
        r_rpos       <= n_rpos;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_trunc  <= n_res_trunc;
        r_res_char   <= n_res_char;
        r_o_status   <= n_o_status;
        r_o_slot     <= n_o_slot;
        r_o_count    <= n_o_count;
        r_o_trunc    <= n_o_trunc;
        r_o_char     <= n_o_char;
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_insert_slot = r_o_slot;
    assign o_count       = r_o_count;
    assign o_truncated   = r_o_trunc;
    assign o_char_out    = r_o_char;

    // Checks
    `ASSERT_ALWAYS(a_count_max, i_clk, i_rst_n,
        r_count <= CNT_W'(LIST_MAX), "count above table size")
    `ASSERT_ALWAYS(a_plen_max, i_clk, i_rst_n,
        r_plen <= POS_W'(NAME_LEN - 1), "pending name too long")
    `ASSERT_IMPLY(a_ins_room, i_clk, i_rst_n, r_state == S_INSERT,
        r_count < CNT_W'(LIST_MAX), "insert into full table")
    `ASSERT_NEXT(a_ins_count, i_clk, i_rst_n, r_state == S_INSERT,
        r_count == CNT_W'($past(r_count) + 1'b1), "insert did not bump count")
    `ASSERT_IMPLY(a_scan_range, i_clk, i_rst_n, r_state == S_SCAN || r_state == S_EVAL,
        CNT_W'(r_k) <= r_count, "scan past last slot")

endmodule

### sim/sorted_name_table_insert_test.sv
`timescale 1ns / 1ps

module sorted_name_table_insert_test import snt_pkg::*;;

    // One input beat as offered to the block
    typedef struct {
        logic       op;
        logic [7:0] ch;
        logic       last;
        logic [2:0] slot;
        logic [6:0] pos;
    } t_entry_beat;

    // One reply beat, field order matches the output ports
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] slot;
        logic [3:0] count;
        logic       truncated;
        logic [7:0] char_out;
    } t_table_reply;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic       i_op = OP_CHAR;
    logic [7:0] i_char_in = 8'h01;
    logic       i_last = 1'b0;
    logic [2:0] i_read_slot = 3'd0;
    logic [6:0] i_read_pos = 7'd0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [1:0] o_status;
    logic [2:0] o_insert_slot;
    logic [3:0] o_count;
    logic       o_truncated;
    logic [7:0] o_char_out;

    sorted_name_table_insert dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_char_in    (i_char_in),
        .i_last       (i_last),
        .i_read_slot  (i_read_slot),
        .i_read_pos   (i_read_pos),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_insert_slot(o_insert_slot),
        .o_count      (o_count),
        .o_truncated  (o_truncated),
        .o_char_out   (o_char_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Beats waiting to be offered, replies waiting to arrive
    t_entry_beat  entry_beats[$];
    t_table_reply pending_replies[$];
    int           beats_made = 0;
    int           errors = 0;
    int           replies_seen = 0;

    // Shadow copy of the name table
    logic [7:0] stored_name [LIST_MAX][NAME_LEN];
    int         stored_len [LIST_MAX];
    int         stored_count = 0;
    logic [7:0] open_name [NAME_LEN];
    int         open_len = 0;
    logic       open_over = 1'b0;

    // True if the name being collected sorts strictly ahead of slot s
    function automatic bit name_precedes(int s);
        int n;
        int i;
        n = (open_len < stored_len[s]) ? open_len : stored_len[s];
        for (i = 0; i < n; i++) begin
            if (open_name[i] != stored_name[s][i])
                return open_name[i] < stored_name[s][i];
        end
        return open_len < stored_len[s];
    endfunction

    // Apply one accepted beat to the shadow table, queue the reply it causes
    task automatic apply_table_beat(input t_entry_beat b);
        t_table_reply r;
        int k;
        int j;
        int p;
        r = '0;
        if (b.op == OP_READ) begin
            r.count = 4'(stored_count);
            if (int'(b.slot) >= stored_count) begin
                r.status = STAT_EMPTY;
            end else begin
                r.status = STAT_DATA;
                if (int'(b.pos) < stored_len[b.slot])
                    r.char_out = stored_name[b.slot][b.pos];
            end
            pending_replies.push_back(r);
        end else begin
            if (open_len < NAME_LEN - 1) begin
                open_name[open_len] = b.ch;
                open_len++;
            end else begin
                open_over = 1'b1;
            end
            if (b.last) begin
                if (stored_count >= LIST_MAX) begin
                    r.status = STAT_FULL;
                end else begin
                    k = 0;
                    while (k < stored_count && !name_precedes(k))
                        k++;
                    // move later names down one slot
                    for (j = stored_count; j > k; j--) begin
                        for (p = 0; p < NAME_LEN; p++)
                            stored_name[j][p] = stored_name[j-1][p];
                        stored_len[j] = stored_len[j-1];
                    end
                    for (p = 0; p < NAME_LEN; p++)
                        stored_name[k][p] = open_name[p];
                    stored_len[k] = open_len;
                    stored_count++;
                    r.status = STAT_INSERTED;
                    r.slot   = 3'(k);
                end
                r.count     = 4'(stored_count);
                r.truncated = open_over;
                pending_replies.push_back(r);
                open_len  = 0;
                open_over = 1'b0;
            end
        end
    endtask

    // Stimulus builders
    task automatic push_beat(input logic op, input logic [7:0] ch, input logic last,
                             input logic [2:0] slot, input logic [6:0] pos);
        t_entry_beat b;
        b.op   = op;
        b.ch   = ch;
        b.last = last;
        b.slot = slot;
        b.pos  = pos;
        entry_beats.push_back(b);
        beats_made++;
    endtask

    // read beat; char and last carry noise
    task automatic push_read(input logic [2:0] slot, input logic [6:0] pos);
        push_beat(OP_READ, 8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)), slot, pos);
    endtask

    // character beat; slot and position carry noise
    task automatic push_char(input logic [7:0] ch, input logic last);
        push_beat(OP_CHAR, ch, last, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 79)));
    endtask

    // Name of len characters, mostly from a tiny alphabet so prefixes collide,
    // with reads dropped in between characters now and then
    task automatic push_name(input int len);
        int i;
        logic [7:0] c;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 15)
                push_read(3'($urandom_range(0, 7)), 7'($urandom_range(0, 79)));
            if ($urandom_range(0, 9) < 7)
                c = 8'h41 + 8'($urandom_range(0, 2));
            else
                c = 8'($urandom_range(1, 255));
            push_char(c, i == len - 1);
        end
    endtask

    // Stimulus, reset and end of run
    initial begin
        // empty table
        push_read(3'd0, 7'd0);
        push_read(3'd7, 7'd79);
        // extreme bytes, a prefix and a duplicate
        push_char(8'hFF, 1'b1);
        push_char(8'h01, 1'b1);
        push_char(8'h01, 1'b0);
        push_char(8'hFF, 1'b1);
        push_char(8'h01, 1'b1);
        push_read(3'd0, 7'd0);
        push_read(3'd1, 7'd1);
        push_read(3'd2, 7'd1);
        push_read(3'd3, 7'd0);
        push_read(3'd4, 7'd0);
        push_read(3'd7, 7'd79);
        // read in the middle of a name
        push_char(8'h80, 1'b0);
        push_read(3'd0, 7'd0);
        push_char(8'h7F, 1'b1);
        push_read(3'd4, 7'd1);
        push_read(3'd4, 7'd0);
        push_read(3'd5, 7'd0);

        // fill the rest: one short, one at full length, one truncated
        push_name($urandom_range(1, 4));
        push_name(NAME_LEN - 1);
        push_name(NAME_LEN + 12);
        // table now full: overlong name on a full table
        push_name(NAME_LEN + 5);
        while (beats_made < 1100) begin
            if ($urandom_range(0, 99) < 55) begin
                if ($urandom_range(0, 1) == 0)
                    push_read(3'($urandom_range(0, 7)), 7'($urandom_range(0, 7)));
                else
                    push_read(3'($urandom_range(0, 7)), 7'($urandom_range(0, 79)));
            end else begin
                push_name($urandom_range(1, 6));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (entry_beats.size() != 0 || i_valid || pending_replies.size() != 0)
            @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: stall pattern, plus one long hold-off to back up the block
    logic [12:0] stall_pat = 13'b1101111011011;
    int          rx_cycle = 0;
    int          hold_left = 0;
    logic        held_once = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            rx_cycle  <= rx_cycle + 1;
            stall_pat <= {stall_pat[0], stall_pat[12:1]};
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_ready   <= 1'b0;
            end else if (!held_once && replies_seen >= 150) begin
                held_once <= 1'b1;
                hold_left <= 400;
                i_ready   <= 1'b0;
            end else if (rx_cycle[7]) begin
                i_ready <= stall_pat[0];
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Driver: bursts with gaps; no gaps while the receiver holds off
    int          burst_left = 1;
    int          gap_left = 0;
    t_entry_beat next_beat;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                next_beat.op   = i_op;
                next_beat.ch   = i_char_in;
                next_beat.last = i_last;
                next_beat.slot = i_read_slot;
                next_beat.pos  = i_read_pos;
                apply_table_beat(next_beat);
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0 && hold_left == 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (entry_beats.size() != 0) begin
                    next_beat = entry_beats.pop_front();
                    i_op        <= next_beat.op;
                    i_char_in   <= next_beat.ch;
                    i_last      <= next_beat.last;
                    i_read_slot <= next_beat.slot;
                    i_read_pos  <= next_beat.pos;
                    i_valid     <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: each reply against the oldest one expected
    t_table_reply want;
    t_table_reply got;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            replies_seen <= replies_seen + 1;
            got = {o_status, o_insert_slot, o_count, o_truncated, o_char_out};
            if (pending_replies.size() == 0) begin
                if (errors < 10)
                    $display("unexpected reply: status %0d slot %0d count %0d trunc %0d char %h",
                             got.status, got.slot, got.count, got.truncated, got.char_out);
                errors <= errors + 1;
            end else begin
                want = pending_replies.pop_front();
                if (got !== want) begin
                    if (errors < 10)
                        $display("reply %0d (status/slot/count/trunc/char) exp %0d/%0d/%0d/%0d/%h",
                                 replies_seen, want.status, want.slot, want.count,
                                 want.truncated, want.char_out,
                                 " got %0d/%0d/%0d/%0d/%h",
                                 got.status, got.slot, got.count, got.truncated,
                                 got.char_out);
                    errors <= errors + 1;
                end
            end
        end
    end

endmodule

### filelist.f
+incdir+hdl
hdl/snt_pkg.sv
hdl/snt_slot_map.sv
hdl/sorted_name_table_insert.sv
sim/sorted_name_table_insert_test.sv
